[rtl/core/vna_pkg.sv]
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants of the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

   localparam int MAX_VERTICES_DEF = 1024;

   localparam int OP_W  = 2;
   localparam int IDX_W = 10;
   localparam int POS_W = 24;
   localparam int DIF_W = POS_W + 1;
   localparam int PRD_W = 2 * DIF_W;
   localparam int SUM_W = 32;
   localparam int CNT_W = 16;
   localparam int NRM_W = 16;
   localparam int VEC_W = 52;
   localparam int MAG_W = VEC_W;

   localparam int REQ_W = 112;
   localparam int RSP_W = 64;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_TRI   = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      logic signed [NRM_W-1:0] z;
      logic signed [NRM_W-1:0] y;
      logic signed [NRM_W-1:0] x;
   } nrm_type;

endpackage

[rtl/core/vna_ram.sv]
// ----------------------------------------------------------------------------
// vna_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vna_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/vna_unit.sv]
// ----------------------------------------------------------------------------
// vna_unit
// Iterative unit-length scaler: normalizes a 3-vector to Q1.14 by a
// bit-serial shift, squares, a digit-serial square root and a long division.
// ----------------------------------------------------------------------------
module vna_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [vna_pkg::VEC_W-1:0]  vec_x,
   input  logic signed [vna_pkg::VEC_W-1:0]  vec_y,
   input  logic signed [vna_pkg::VEC_W-1:0]  vec_z,
   output logic                              done,
   output vna_pkg::nrm_type                  result
);

   localparam int MW = vna_pkg::MAG_W;
   localparam int NW = vna_pkg::NRM_W;
   localparam int QW = NW - 1;
   localparam logic [MW-1:0] NORM_HI = {{(MW-31){1'b0}}, 1'b1, 30'b0};
   localparam logic [MW-1:0] NORM_LO = {{(MW-30){1'b0}}, 1'b1, 29'b0};

   typedef enum logic [2:0] {U_IDLE, U_NORM, U_SQ, U_SQRT, U_DINIT, U_DIV} ustate_type;

   ustate_type           state_ff;
   logic [MW-1:0]        mag_ff [3];
   logic                 neg_ff [3];
   logic [59:0]          prod_ff;
   logic [61:0]          s_ff;
   logic [61:0]          x_ff;
   logic [62:0]          r_ff;
   logic [62:0]          rbit_ff;
   logic [4:0]           cnt_ff;
   logic [1:0]           comp_ff;
   logic [30:0]          len_ff;
   logic [31:0]          rem_ff;
   logic [QW-1:0]        low_ff;
   logic [QW-1:0]        q_ff;
   logic signed [NW-1:0] res_ff [3];
   logic                 done_ff;

   logic [MW-1:0] m_max;
   logic [MW-1:0] abs_x, abs_y, abs_z;
   logic [62:0]   sq_t, x_ext, r_nx;
   logic          sq_ge;
   logic [45:0]   num;
   logic [32:0]   rem2, den_ext;
   logic          dv_ge;
   logic [QW-1:0] q_nx;
   logic signed [NW-1:0] q_signed;

   always_comb begin
      abs_x = vec_x[vna_pkg::VEC_W-1] ? MW'(-vec_x) : MW'(vec_x);
      abs_y = vec_y[vna_pkg::VEC_W-1] ? MW'(-vec_y) : MW'(vec_y);
      abs_z = vec_z[vna_pkg::VEC_W-1] ? MW'(-vec_z) : MW'(vec_z);
      m_max = mag_ff[0];
      if (mag_ff[1] > m_max) begin
         m_max = mag_ff[1];
      end
      if (mag_ff[2] > m_max) begin
         m_max = mag_ff[2];
      end
      // One step of the digit-by-digit square root.
      sq_t  = r_ff + rbit_ff;
      x_ext = {1'b0, x_ff};
      sq_ge = (x_ext >= sq_t);
      r_nx  = sq_ge ? ((r_ff >> 1) + rbit_ff) : (r_ff >> 1);
      // Numerator of the rounded quotient is mag * 2^15 + L over 2L.
      num     = {1'b0, mag_ff[0][29:0], 15'b0} + {15'b0, len_ff};
      rem2    = {rem_ff, low_ff[QW-1]};
      den_ext = {1'b0, len_ff, 1'b0};
      dv_ge   = (rem2 >= den_ext);
      q_nx    = {q_ff[QW-2:0], dv_ge};
      q_signed = neg_ff[0] ? -$signed({1'b0, q_nx}) : $signed({1'b0, q_nx});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            U_IDLE: begin
               if (start) begin
                  mag_ff[0] <= abs_x;
                  mag_ff[1] <= abs_y;
                  mag_ff[2] <= abs_z;
                  neg_ff[0] <= vec_x[vna_pkg::VEC_W-1];
                  neg_ff[1] <= vec_y[vna_pkg::VEC_W-1];
                  neg_ff[2] <= vec_z[vna_pkg::VEC_W-1];
                  state_ff  <= U_NORM;
               end
            end
            U_NORM: begin
               if (m_max == '0) begin
                  res_ff[0] <= '0;
                  res_ff[1] <= '0;
                  res_ff[2] <= '0;
                  done_ff   <= 1'b1;
                  state_ff  <= U_IDLE;
               end else if (m_max >= NORM_HI) begin
                  mag_ff[0] <= mag_ff[0] >> 1;
                  mag_ff[1] <= mag_ff[1] >> 1;
                  mag_ff[2] <= mag_ff[2] >> 1;
               end else if (m_max < NORM_LO) begin
                  mag_ff[0] <= mag_ff[0] << 1;
                  mag_ff[1] <= mag_ff[1] << 1;
                  mag_ff[2] <= mag_ff[2] << 1;
               end else begin
                  s_ff     <= '0;
                  cnt_ff   <= '0;
                  state_ff <= U_SQ;
               end
            end
            U_SQ: begin
               // Squares go through the multiplier one component a cycle.
               if (cnt_ff != 5'd3) begin
                  prod_ff   <= mag_ff[0][29:0] * mag_ff[0][29:0];
                  mag_ff[0] <= mag_ff[1];
                  mag_ff[1] <= mag_ff[2];
                  mag_ff[2] <= mag_ff[0];
                  neg_ff[0] <= neg_ff[1];
                  neg_ff[1] <= neg_ff[2];
                  neg_ff[2] <= neg_ff[0];
               end
               if (cnt_ff != 5'd0) begin
                  s_ff <= s_ff + {2'b0, prod_ff};
               end
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd3) begin
                  x_ff     <= s_ff + {2'b0, prod_ff};
                  r_ff     <= '0;
                  rbit_ff  <= {1'b1, 62'b0};
                  cnt_ff   <= '0;
                  state_ff <= U_SQRT;
               end
            end
            U_SQRT: begin
               if (sq_ge) begin
                  x_ff <= 62'(x_ext - sq_t);
               end
               r_ff    <= r_nx;
               rbit_ff <= rbit_ff >> 2;
               cnt_ff  <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  len_ff   <= r_nx[30:0];
                  comp_ff  <= '0;
                  state_ff <= U_DINIT;
               end
            end
            U_DINIT: begin
               rem_ff   <= {1'b0, num[45:15]};
               low_ff   <= num[QW-1:0];
               q_ff     <= '0;
               cnt_ff   <= '0;
               state_ff <= U_DIV;
            end
            U_DIV: begin
               rem_ff <= dv_ge ? 32'(rem2 - den_ext) : rem2[31:0];
               low_ff <= low_ff << 1;
               q_ff   <= q_nx;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(QW - 1)) begin
                  res_ff[0] <= res_ff[1];
                  res_ff[1] <= res_ff[2];
                  res_ff[2] <= q_signed;
                  mag_ff[0] <= mag_ff[1];
                  mag_ff[1] <= mag_ff[2];
                  mag_ff[2] <= mag_ff[0];
                  neg_ff[0] <= neg_ff[1];
                  neg_ff[1] <= neg_ff[2];
                  neg_ff[2] <= neg_ff[0];
                  if (comp_ff == 2'd2) begin
                     done_ff  <= 1'b1;
                     state_ff <= U_IDLE;
                  end else begin
                     comp_ff  <= comp_ff + 2'd1;
                     state_ff <= U_DINIT;
                  end
               end
            end
            default: begin
               state_ff <= U_IDLE;
            end
         endcase
      end
   end

   assign done     = done_ff;
   assign result.x = res_ff[0];
   assign result.y = res_ff[1];
   assign result.z = res_ff[2];

endmodule

[rtl/core/vertex_normal_accumulator.sv]
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Smooth per-vertex normals by face averaging in fixed point.
// ----------------------------------------------------------------------------
// Usage: items arrive on the req_ stream. tuser carries the operation (load
// position, add triangle, read normal, clear sums). Loads are written in the
// cycle of the transfer. A triangle fetches its three corners, forms the
// cross product on one multiplier, scales it to unit length in the shared
// scaler, then updates each corner's sum and count; a degenerate face leaves
// the scaler early with a zero normal. The scaler shifts one bit a cycle to
// normalize, then runs a 32-step square root and three 15-step divisions.
// A read of a used vertex is scaled the same way; an unused vertex or an
// index out of range skips the scaler. Then one result goes out on the rsp_
// stream. Reset and a clear item both start a clearing pass over the sum
// memory, during which req_tready is low. Positions are kept.
// The result sits in an output register; while the receiver stalls the block
// still takes loads and triangles, and a later read waits for the register.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator #(
   parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // vtx_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
   input  logic [vna_pkg::REQ_W-1:0]  req_tdata,
   // operation
   input  logic [vna_pkg::OP_W-1:0]   req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // read_index, normal_x, normal_y, normal_z, zero fill
   output logic [vna_pkg::RSP_W-1:0]  rsp_tdata,
   // vertex_used
   output logic                       rsp_tuser
);

   localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int IW  = vna_pkg::IDX_W;
   localparam int PW  = vna_pkg::POS_W;
   localparam int DW  = vna_pkg::DIF_W;
   localparam int SW  = vna_pkg::SUM_W;
   localparam int CW  = vna_pkg::CNT_W;
   localparam int VW  = vna_pkg::VEC_W;
   localparam int SMW = 3 * SW + CW;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_RD_C, S_RD_W, S_CROSS, S_UNIT,
      S_ACC_RD, S_ACC_WR, S_RS_RD, S_RS_CHK, S_OUT
   } state_type;

   state_type state_ff;

   // Request fields.
   logic [IW-1:0] f_idx, f_a, f_b, f_c;
   logic signed [PW-1:0] f_px, f_py, f_pz;
   vna_pkg::op_type f_op;
   logic req_xfer;

   assign f_idx = req_tdata[9:0];
   assign f_px  = req_tdata[33:10];
   assign f_py  = req_tdata[57:34];
   assign f_pz  = req_tdata[81:58];
   assign f_a   = req_tdata[91:82];
   assign f_b   = req_tdata[101:92];
   assign f_c   = req_tdata[111:102];
   assign f_op  = vna_pkg::op_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   function automatic logic in_range(input logic [IW-1:0] idx);
      return 32'(idx) < 32'(MAX_VERTICES);
   endfunction

   // Registers of the sequencer.
   logic [AW-1:0]        clr_addr_ff;
   logic [IW-1:0]        vi_ff;
   logic [AW-1:0]        corner_ff [3];
   logic                 is_read_ff;
   logic signed [PW-1:0] pa_x_ff, pa_y_ff, pa_z_ff;
   logic signed [DW-1:0] e1_ff [3];
   logic signed [DW-1:0] e2_ff [3];
   logic [2:0]           k_ff;
   logic signed [vna_pkg::PRD_W-1:0] prod_ff, tmp_ff;
   logic signed [VW-1:0] cr_ff [3];
   logic                 unit_start_ff;
   vna_pkg::nrm_type     nrm_ff;
   logic                 used_ff;
   logic [1:0]           acc_cnt_ff;
   logic                 rsp_valid_ff;
   logic [vna_pkg::RSP_W-1:0] rsp_data_ff;
   logic                 rsp_user_ff;

   // Memories.
   logic                  pos_we;
   logic [AW-1:0]         pos_raddr;
   logic [3*PW-1:0]       pos_rdata;
   logic                  sum_we;
   logic [AW-1:0]         sum_waddr, sum_raddr;
   logic [SMW-1:0]        sum_wdata, sum_rdata;

   logic signed [PW-1:0]  rd_x, rd_y, rd_z;
   logic signed [SW-1:0]  sm_x, sm_y, sm_z;
   logic [CW-1:0]         sm_cnt;
   logic signed [DW-1:0]  mul_a, mul_b;
   logic                  unit_done;
   vna_pkg::nrm_type      unit_res;

   assign rd_x   = pos_rdata[PW-1:0];
   assign rd_y   = pos_rdata[2*PW-1:PW];
   assign rd_z   = pos_rdata[3*PW-1:2*PW];
   assign sm_x   = sum_rdata[SW-1:0];
   assign sm_y   = sum_rdata[2*SW-1:SW];
   assign sm_z   = sum_rdata[3*SW-1:2*SW];
   assign sm_cnt = sum_rdata[SMW-1:3*SW];

   function automatic logic [SW-1:0] sat_add(input logic signed [SW-1:0] s,
                                             input logic signed [vna_pkg::NRM_W-1:0] n);
      logic signed [SW:0] t;
      t = {s[SW-1], s} + (SW+1)'(n);
      if (t[SW] != t[SW-1]) begin
         return t[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end
      return t[SW-1:0];
   endfunction

   always_comb begin
      pos_we = req_xfer && (f_op == vna_pkg::OP_LOAD) && in_range(f_idx);
      case (state_ff)
         S_RD_A:  pos_raddr = corner_ff[0];
         S_RD_B:  pos_raddr = corner_ff[1];
         default: pos_raddr = corner_ff[2];
      endcase
      sum_raddr = (state_ff == S_RS_RD) ? AW'(vi_ff) : corner_ff[0];
      sum_we    = (state_ff == S_CLEAR) || (state_ff == S_ACC_WR);
      sum_waddr = (state_ff == S_CLEAR) ? clr_addr_ff : corner_ff[0];
      if (state_ff == S_CLEAR) begin
         sum_wdata = '0;
      end else begin
         sum_wdata = {(sm_cnt == {CW{1'b1}}) ? sm_cnt : sm_cnt + CW'(1),
                      sat_add(sm_z, nrm_ff.z), sat_add(sm_y, nrm_ff.y),
                      sat_add(sm_x, nrm_ff.x)};
      end
      case (k_ff)
         3'd0:    begin mul_a = e1_ff[1]; mul_b = e2_ff[2]; end
         3'd1:    begin mul_a = e1_ff[2]; mul_b = e2_ff[1]; end
         3'd2:    begin mul_a = e1_ff[2]; mul_b = e2_ff[0]; end
         3'd3:    begin mul_a = e1_ff[0]; mul_b = e2_ff[2]; end
         3'd4:    begin mul_a = e1_ff[0]; mul_b = e2_ff[1]; end
         default: begin mul_a = e1_ff[1]; mul_b = e2_ff[0]; end
      endcase
   end

   vna_ram #(.DEPTH(MAX_VERTICES), .WIDTH(3 * PW)) u_pos_ram (
      .clock (clock),
      .we    (pos_we),
      .waddr (AW'(f_idx)),
      .wdata ({f_pz, f_py, f_px}),
      .raddr (pos_raddr),
      .rdata (pos_rdata)
   );

   vna_ram #(.DEPTH(MAX_VERTICES), .WIDTH(SMW)) u_sum_ram (
      .clock (clock),
      .we    (sum_we),
      .waddr (sum_waddr),
      .wdata (sum_wdata),
      .raddr (sum_raddr),
      .rdata (sum_rdata)
   );

   vna_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .start  (unit_start_ff),
      .vec_x  (cr_ff[0]),
      .vec_y  (cr_ff[1]),
      .vec_z  (cr_ff[2]),
      .done   (unit_done),
      .result (unit_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         unit_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         unit_start_ff <= 1'b0;
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
               if (clr_addr_ff == LAST_ADDR) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_xfer) begin
                  vi_ff        <= f_idx;
                  corner_ff[0] <= AW'(f_a);
                  corner_ff[1] <= AW'(f_b);
                  corner_ff[2] <= AW'(f_c);
                  case (f_op)
                     vna_pkg::OP_TRI: begin
                        is_read_ff <= 1'b0;
                        if (in_range(f_a) && in_range(f_b) && in_range(f_c)) begin
                           state_ff <= S_RD_A;
                        end
                     end
                     vna_pkg::OP_READ: begin
                        is_read_ff <= 1'b1;
                        if (in_range(f_idx)) begin
                           state_ff <= S_RS_RD;
                        end else begin
                           nrm_ff   <= '0;
                           used_ff  <= 1'b0;
                           state_ff <= S_OUT;
                        end
                     end
                     vna_pkg::OP_CLEAR: begin
                        clr_addr_ff <= '0;
                        state_ff    <= S_CLEAR;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_RD_A: state_ff <= S_RD_B;
            S_RD_B: begin
               pa_x_ff  <= rd_x;
               pa_y_ff  <= rd_y;
               pa_z_ff  <= rd_z;
               state_ff <= S_RD_C;
            end
            S_RD_C: begin
               e1_ff[0] <= DW'(rd_x) - DW'(pa_x_ff);
               e1_ff[1] <= DW'(rd_y) - DW'(pa_y_ff);
               e1_ff[2] <= DW'(rd_z) - DW'(pa_z_ff);
               state_ff <= S_RD_W;
            end
            S_RD_W: begin
               e2_ff[0] <= DW'(rd_x) - DW'(pa_x_ff);
               e2_ff[1] <= DW'(rd_y) - DW'(pa_y_ff);
               e2_ff[2] <= DW'(rd_z) - DW'(pa_z_ff);
               k_ff     <= '0;
               state_ff <= S_CROSS;
            end
            S_CROSS: begin
               // One product a cycle; each odd product closes a component.
               prod_ff <= mul_a * mul_b;
               k_ff    <= k_ff + 3'd1;
               case (k_ff)
                  3'd1, 3'd3, 3'd5: tmp_ff <= prod_ff;
                  3'd2: cr_ff[0] <= VW'(tmp_ff) - VW'(prod_ff);
                  3'd4: cr_ff[1] <= VW'(tmp_ff) - VW'(prod_ff);
                  3'd6: begin
                     cr_ff[2]      <= VW'(tmp_ff) - VW'(prod_ff);
                     unit_start_ff <= 1'b1;
                     state_ff      <= S_UNIT;
                  end
                  default: begin
                  end
               endcase
            end
            S_UNIT: begin
               if (unit_done) begin
                  nrm_ff     <= unit_res;
                  acc_cnt_ff <= '0;
                  state_ff   <= is_read_ff ? S_OUT : S_ACC_RD;
               end
            end
            S_ACC_RD: state_ff <= S_ACC_WR;
            S_ACC_WR: begin
               corner_ff[0] <= corner_ff[1];
               corner_ff[1] <= corner_ff[2];
               corner_ff[2] <= corner_ff[0];
               acc_cnt_ff   <= acc_cnt_ff + 2'd1;
               state_ff     <= (acc_cnt_ff == 2'd2) ? S_IDLE : S_ACC_RD;
            end
            S_RS_RD: state_ff <= S_RS_CHK;
            S_RS_CHK: begin
               if (sm_cnt == '0) begin
                  nrm_ff   <= '0;
                  used_ff  <= 1'b0;
                  state_ff <= S_OUT;
               end else begin
                  cr_ff[0]      <= VW'(sm_x);
                  cr_ff[1]      <= VW'(sm_y);
                  cr_ff[2]      <= VW'(sm_z);
                  used_ff       <= 1'b1;
                  unit_start_ff <= 1'b1;
                  state_ff      <= S_UNIT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {6'b0, nrm_ff.z, nrm_ff.y, nrm_ff.x, vi_ff};
                  rsp_user_ff  <= used_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_unit_done_expected: assert property (@(posedge clock) disable iff (reset)
      unit_done |-> (state_ff == S_UNIT))
      else $error("scaler finished while the sequencer was not waiting");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("block ready before the clearing pass");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && f_op == vna_pkg::OP_READ) |=> !req_tready)
      else $error("read transfer did not occupy the block");

   a_sum_write_owner: assert property (@(posedge clock) disable iff (reset)
      sum_we |-> !req_tready)
      else $error("sum memory written while idle");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the vertex normal accumulator. Loads, triangles,
// reads and clears go in on the req_ stream; a local model of the sums and
// counts predicts each read, and every rsp_ transfer is compared against the
// oldest predicted normal. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NV        = vna_pkg::MAX_VERTICES_DEF;
   localparam int WDOG_MAX  = 8000;
   localparam int TAIL_WAIT = 200;

   typedef struct {
      logic [vna_pkg::IDX_W-1:0]        index;
      logic signed [vna_pkg::NRM_W-1:0] nx;
      logic signed [vna_pkg::NRM_W-1:0] ny;
      logic signed [vna_pkg::NRM_W-1:0] nz;
      logic                             used;
   } normal_read_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [vna_pkg::REQ_W-1:0]  req_tdata = '0;
   logic [vna_pkg::OP_W-1:0]   req_tuser = vna_pkg::OP_LOAD;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [vna_pkg::RSP_W-1:0]  rsp_tdata;
   logic                       rsp_tuser;

   // Model state of the block.
   int          pos_x_mem [NV];
   int          pos_y_mem [NV];
   int          pos_z_mem [NV];
   int          sum_x_mem [NV];
   int          sum_y_mem [NV];
   int          sum_z_mem [NV];
   int unsigned use_cnt_mem [NV];
   bit          loaded [NV];
   int          loaded_list [$];

   normal_read_type pending_normals [$];
   int  error_count = 0;
   int  idle_cycles = 0;
   int  rsp_stall = 0;
   bit  calm = 1'b0;

   vertex_normal_accumulator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic longint unsigned isqrt(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Scales a vector to unit length in Q1.14, after normalizing its largest
   // magnitude into [2^29, 2^30).
   function automatic void unit_scale(input longint v0, v1, v2,
                                      output int o0, o1, o2);
      longint          v [3];
      longint unsigned mg [3];
      longint unsigned m, s, len, q;
      int              o [3];
      v = '{v0, v1, v2};
      m = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         mg[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
         if (mg[i] > m) m = mg[i];
      end
      o = '{0, 0, 0};
      if (m != 0) begin
         while (m >= (64'd1 << 30)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
         end
         while (m < (64'd1 << 29)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mg[i] = mg[i] << 1;
         end
         for (int i = 0; i < 3; i++) s = s + mg[i] * mg[i];
         len = isqrt(s);
         for (int i = 0; i < 3; i++) begin
            q = ((mg[i] << 15) + len) / (2 * len);
            o[i] = (v[i] < 0) ? -int'(q) : int'(q);
         end
      end
      o0 = o[0];
      o1 = o[1];
      o2 = o[2];
   endfunction

   function automatic int sat_add(input int a, input int b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return int'(s);
   endfunction

   function automatic void add_to_corner(input int k, input int nx, ny, nz);
      sum_x_mem[k] = sat_add(sum_x_mem[k], nx);
      sum_y_mem[k] = sat_add(sum_y_mem[k], ny);
      sum_z_mem[k] = sat_add(sum_z_mem[k], nz);
      if (use_cnt_mem[k] != 65535) use_cnt_mem[k]++;
   endfunction

   function automatic void clear_sums();
      for (int i = 0; i < NV; i++) begin
         sum_x_mem[i] = 0;
         sum_y_mem[i] = 0;
         sum_z_mem[i] = 0;
         use_cnt_mem[i] = 0;
      end
   endfunction

   // Applies one accepted item to the model and queues the normal of a read.
   function automatic void predict_normals(input vna_pkg::op_type op, input int vi,
         input logic signed [vna_pkg::POS_W-1:0] px, py, pz, input int ca, cb, cc);
      longint          e1x, e1y, e1z, e2x, e2y, e2z;
      int              nx, ny, nz;
      normal_read_type rd;
      case (op)
         vna_pkg::OP_LOAD: begin
            pos_x_mem[vi] = px;
            pos_y_mem[vi] = py;
            pos_z_mem[vi] = pz;
            if (!loaded[vi]) loaded_list = {loaded_list, vi};
            loaded[vi] = 1'b1;
         end
         vna_pkg::OP_TRI: begin
            e1x = longint'(pos_x_mem[cb]) - pos_x_mem[ca];
            e1y = longint'(pos_y_mem[cb]) - pos_y_mem[ca];
            e1z = longint'(pos_z_mem[cb]) - pos_z_mem[ca];
            e2x = longint'(pos_x_mem[cc]) - pos_x_mem[ca];
            e2y = longint'(pos_y_mem[cc]) - pos_y_mem[ca];
            e2z = longint'(pos_z_mem[cc]) - pos_z_mem[ca];
            unit_scale(e1y * e2z - e1z * e2y, e1z * e2x - e1x * e2z,
                       e1x * e2y - e1y * e2x, nx, ny, nz);
            add_to_corner(ca, nx, ny, nz);
            add_to_corner(cb, nx, ny, nz);
            add_to_corner(cc, nx, ny, nz);
         end
         vna_pkg::OP_READ: begin
            rd.index = vi[vna_pkg::IDX_W-1:0];
            rd.nx = '0;
            rd.ny = '0;
            rd.nz = '0;
            rd.used = (use_cnt_mem[vi] != 0);
            if (rd.used) begin
               unit_scale(sum_x_mem[vi], sum_y_mem[vi], sum_z_mem[vi], nx, ny, nz);
               rd.nx = nx[vna_pkg::NRM_W-1:0];
               rd.ny = ny[vna_pkg::NRM_W-1:0];
               rd.nz = nz[vna_pkg::NRM_W-1:0];
            end
            pending_normals = {pending_normals, rd};
         end
         default: clear_sums();
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint got, want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // Sends one item; the gap in front of it is random unless calm is set.
   task automatic send_item(input vna_pkg::op_type op, input int vi,
         input int px, py, pz, input int ca, cb, cc);
      int gap, r;
      logic signed [vna_pkg::POS_W-1:0] sx, sy, sz;
      sx = px[vna_pkg::POS_W-1:0];
      sy = py[vna_pkg::POS_W-1:0];
      sz = pz[vna_pkg::POS_W-1:0];
      r = $urandom_range(0, 99);
      gap = calm ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3)
                                                : $urandom_range(10, 60);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {cc[vna_pkg::IDX_W-1:0], cb[vna_pkg::IDX_W-1:0],
                     ca[vna_pkg::IDX_W-1:0], sz, sy, sx, vi[vna_pkg::IDX_W-1:0]};
      do @(posedge clock); while (!req_tready);
      predict_normals(op, vi, sx, sy, sz, ca, cb, cc);
   endtask

   task automatic load_vertex(input int vi, input int x, y, z);
      send_item(vna_pkg::OP_LOAD, vi, x, y, z, $urandom_range(0, NV - 1),
                $urandom_range(0, NV - 1), $urandom_range(0, NV - 1));
   endtask

   task automatic add_triangle(input int a, b, c);
      send_item(vna_pkg::OP_TRI, $urandom_range(0, NV - 1), $urandom, $urandom,
                $urandom, a, b, c);
   endtask

   task automatic read_normal(input int vi);
      send_item(vna_pkg::OP_READ, vi, $urandom, $urandom, $urandom,
                $urandom_range(0, NV - 1), $urandom_range(0, NV - 1),
                $urandom_range(0, NV - 1));
   endtask

   task automatic clear_all();
      send_item(vna_pkg::OP_CLEAR, $urandom_range(0, NV - 1), $urandom, $urandom,
                $urandom, $urandom_range(0, NV - 1), $urandom_range(0, NV - 1),
                $urandom_range(0, NV - 1));
   endtask

   task automatic wait_for_results();
      while (pending_normals.size() != 0) @(posedge clock);
   endtask

   task automatic test_field_extremes();
      load_vertex(0, 0, 0, 0);
      load_vertex(1, 4096, 0, 0);
      load_vertex(2, 0, 4096, 0);
      load_vertex(3, 8388607, 8388607, 8388607);
      load_vertex(4, -8388608, -8388608, -8388608);
      load_vertex(5, 8388607, -8388608, 0);
      load_vertex(1023, -1, 1, 8388607);
      read_normal(0);
      read_normal(1023);
      add_triangle(0, 1, 2);
      read_normal(0);
      add_triangle(3, 4, 5);
      add_triangle(5, 4, 3);
      read_normal(3);
      add_triangle(1023, 0, 3);
      read_normal(1023);
   endtask

   // Degenerate faces, repeated corners and a pair of faces that cancel.
   task automatic test_special_faces();
      load_vertex(6, 8192, 0, 0);
      add_triangle(0, 1, 6);
      read_normal(6);
      add_triangle(0, 0, 1);
      add_triangle(2, 1, 2);
      add_triangle(0, 2, 1);
      read_normal(2);
      read_normal(1);
   endtask

   task automatic test_clear();
      clear_all();
      read_normal(0);
      add_triangle(0, 1, 2);
      read_normal(1);
   endtask

   task automatic random_item();
      int r, vi;
      r = $urandom_range(0, 99);
      if (r < 25 || loaded_list.size() < 3) begin
         vi = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 63)
                                         : $urandom_range(0, NV - 1);
         if ($urandom_range(0, 3) == 0)
            load_vertex(vi, $urandom_range(0, 8191) - 4096,
                        $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096);
         else
            load_vertex(vi, $urandom, $urandom, $urandom);
      end else if (r < 70) begin
         add_triangle(loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                      loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                      loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
      end else if (r < 98) begin
         if ($urandom_range(0, 3) == 0)
            read_normal($urandom_range(0, NV - 1));
         else
            read_normal(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
      end else begin
         clear_all();
      end
   endtask

   task automatic test_random_traffic();
      for (int n = 0; n < 1380; n++) begin
         if (n % 200 == 0) calm = ($urandom_range(0, 2) == 0);
         // Halfway through, the sender holds off until the output is drained.
         if (n == 700) begin
            req_tvalid <= 1'b0;
            wait_for_results();
            repeat (300) @(posedge clock);
         end
         random_item();
      end
      calm = 1'b0;
   endtask

   always @(posedge clock) begin : rsp_stall_gen
      int r;
      if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         r = $urandom_range(0, 99);
         if (!calm && r < 10) rsp_stall <= $urandom_range(1, 3);
         else if (!calm && r == 10) rsp_stall <= $urandom_range(20, 80);
      end
   end

   always @(posedge clock) begin : normal_check
      normal_read_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_normals.size() == 0) begin
            report_mismatch("unexpected transfer, index", rsp_tdata[9:0], -1);
         end else begin
            want = pending_normals.pop_front();
            if (rsp_tdata[9:0] !== want.index)
               report_mismatch("read_index", rsp_tdata[9:0], want.index);
            if ($signed(rsp_tdata[25:10]) !== want.nx)
               report_mismatch("normal_x", $signed(rsp_tdata[25:10]), want.nx);
            if ($signed(rsp_tdata[41:26]) !== want.ny)
               report_mismatch("normal_y", $signed(rsp_tdata[41:26]), want.ny);
            if ($signed(rsp_tdata[57:42]) !== want.nz)
               report_mismatch("normal_z", $signed(rsp_tdata[57:42]), want.nz);
            if (rsp_tdata[63:58] !== '0)
               report_mismatch("zero fill", rsp_tdata[63:58], 0);
            if (rsp_tuser !== want.used)
               report_mismatch("vertex_used", rsp_tuser, want.used);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("[vertex_normal_accumulator] ERROR");
         $finish;
      end
   end

   initial begin
      clear_sums();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_special_faces();
      test_clear();
      test_random_traffic();
      req_tvalid <= 1'b0;
      wait_for_results();
      repeat (TAIL_WAIT) @(posedge clock);
      if (error_count == 0 && pending_normals.size() == 0)
         $display("[vertex_normal_accumulator] OK");
      else
         $display("[vertex_normal_accumulator] ERROR");
      $finish;
   end

endmodule
